[src/phist_pkg.sv]
// shared types and constants of the pixel histogram
package phist_pkg;

  localparam int DEF_BINS = 256;
  localparam int CMD_W    = 2;
  localparam int BIN_W    = 8;
  localparam int COUNT_W  = 32;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACCUM = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_ACCUM,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic              hit;
    logic [BIN_W-1:0]  bin;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } head_t;

  typedef struct packed {
    logic pop;
    logic sweeping;
  } back_ctl_t;

endpackage

[src/phist_ram.sv]
// generic single write port ram with registered read
module phist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/phist_front.sv]
// front end: accepts command words, classifies them and queues the work
module phist_front #(
  parameter int BINS = phist_pkg::DEF_BINS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [phist_pkg::CMD_W-1:0]   cmd,
  input  logic [phist_pkg::BIN_W-1:0]   pixel,
  input  logic [phist_pkg::BIN_W-1:0]   read_bin,
  output phist_pkg::head_t              head,
  input  phist_pkg::back_ctl_t          ctl
);
  import phist_pkg::*;

  op_t        q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  op_t        op_in;
  logic       keep;
  logic       push;

  always_comb begin
    keep        = 1'b0;
    op_in.kind  = OP_CLEAR;
    op_in.hit   = 1'b1;
    op_in.bin   = '0;
    case (cmd)
      CMD_CLEAR: begin
        keep = 1'b1;
      end
      CMD_ACCUM: begin
        op_in.kind = OP_ACCUM;
        op_in.bin  = pixel;
        op_in.hit  = int'(pixel) < BINS;
        keep       = op_in.hit;
      end
      CMD_READ: begin
        op_in.kind = OP_READ;
        op_in.bin  = read_bin;
        op_in.hit  = int'(read_bin) < BINS;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready   = !ctl.sweeping && (fill != 2'd2);
  assign push       = in_valid && in_ready && keep;
  assign head.valid = (fill != 2'd0);
  assign head.op    = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (ctl.pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, ctl.pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= op_in;
    end
  end

endmodule

[src/phist_back.sv]
// back end: counter ram with read-modify-write, clearing sweep and result register
module phist_back #(
  parameter int BINS = phist_pkg::DEF_BINS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  phist_pkg::head_t               head,
  output phist_pkg::back_ctl_t           ctl,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [phist_pkg::BIN_W-1:0]    bin,
  output logic [phist_pkg::COUNT_W-1:0]  count
);
  import phist_pkg::*;

  localparam int AW = BINS > 1 ? $clog2(BINS) : 1;
  localparam int IW = AW > BIN_W ? AW : BIN_W;
  localparam logic [AW-1:0] LAST = AW'(BINS - 1);

  logic               sweeping;
  logic [AW-1:0]      sweep_addr;
  logic               s1_valid;
  op_t                s1_op;
  logic               lw_valid;
  logic [AW-1:0]      lw_addr;
  logic [COUNT_W-1:0] lw_data;
  logic [IW-1:0]      head_wide;
  logic [IW-1:0]      s1_wide;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      s1_addr;
  logic [COUNT_W-1:0] rdata;
  logic [COUNT_W-1:0] cur;
  logic [COUNT_W-1:0] inc;
  logic               s1_adv;
  logic               start_clear;
  logic               issue;
  logic               acc_we;
  logic               load;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [COUNT_W-1:0] ram_wdata;

  assign head_wide = IW'(head.op.bin);
  assign s1_wide   = IW'(s1_op.bin);
  assign raddr     = head_wide[AW-1:0];
  assign s1_addr   = s1_wide[AW-1:0];

  assign s1_adv      = !(s1_valid && s1_op.kind == OP_READ && out_valid && !out_ready);
  assign start_clear = head.valid && head.op.kind == OP_CLEAR && !sweeping && !s1_valid;
  assign issue       = head.valid && head.op.kind != OP_CLEAR && !sweeping && s1_adv;
  assign ctl.pop      = start_clear || issue;
  assign ctl.sweeping = sweeping;

  // forward the write that landed on the same edge as this read
  assign cur    = (lw_valid && lw_addr == s1_addr) ? lw_data : rdata;
  assign inc    = cur + COUNT_W'(1);
  assign acc_we = s1_valid && s1_op.kind == OP_ACCUM;
  assign load   = s1_valid && s1_op.kind == OP_READ && s1_adv;

  assign ram_we    = sweeping || acc_we;
  assign ram_waddr = sweeping ? sweep_addr : s1_addr;
  assign ram_wdata = sweeping ? '0 : inc;

  phist_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
      s1_valid   <= 1'b0;
      lw_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (start_clear) begin
        sweeping   <= 1'b1;
        sweep_addr <= '0;
      end else if (sweeping) begin
        if (sweep_addr == LAST) begin
          sweeping <= 1'b0;
        end
        sweep_addr <= sweep_addr + AW'(1);
      end
      if (s1_adv) begin
        s1_valid <= issue;
        lw_valid <= acc_we;
      end
      out_valid <= load || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_op   <= head.op;
      lw_addr <= s1_addr;
      lw_data <= inc;
    end
    if (load) begin
      bin   <= s1_op.bin;
      count <= s1_op.hit ? cur : '0;
    end
  end

`ifndef SYNTHESIS
  a_sweep_alone: assert property (@(posedge clk) disable iff (rst)
    sweeping |-> !s1_valid && !issue)
    else $error("work in flight during clearing sweep");

  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    sweeping && sweep_addr == LAST && !start_clear |=> !sweeping)
    else $error("clearing sweep overran the table");

  a_read_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_op.kind == OP_READ && out_valid && !out_ready
    |=> s1_valid && $stable(s1_op) && $stable(rdata))
    else $error("stalled read lost its data");

  a_fwd_track: assert property (@(posedge clk) disable iff (rst)
    acc_we |=> lw_valid && lw_addr == $past(s1_addr) && lw_data == $past(inc))
    else $error("forwarding register missed a counter write");
`endif

endmodule

[src/pixel_histogram.sv]
// pixel histogram top level: front end, queue and counter back end
// Accumulate and read words enter the counter pipeline one after another, so
// a stream of pixels runs at one per clock while no clearing sweep or stalled
// read holds it; repeated bins back to back are forwarded around the counter
// ram. A read passes from the queue through the ram read and stage s1 into the
// result register. A clear word waits for the pipeline to drain and then sweeps
// the counter ram at one bin per clock through its single write port, with
// in_ready low. After reset the same sweep runs before the first word is taken.
module pixel_histogram #(
  parameter int BINS = phist_pkg::DEF_BINS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [phist_pkg::CMD_W-1:0]    cmd,
  input  logic [phist_pkg::BIN_W-1:0]    pixel,
  input  logic [phist_pkg::BIN_W-1:0]    read_bin,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [phist_pkg::BIN_W-1:0]    bin,
  output logic [phist_pkg::COUNT_W-1:0]  count
);
  import phist_pkg::*;

  head_t     head;
  back_ctl_t ctl;

  phist_front #(
    .BINS (BINS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .pixel    (pixel),
    .read_bin (read_bin),
    .head     (head),
    .ctl      (ctl)
  );

  phist_back #(
    .BINS (BINS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .ctl       (ctl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .bin       (bin),
    .count     (count)
  );

endmodule
